// ===== rtl/emg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emg_pkg
// Shared constants, opcodes, register indexes and the queue word type for the
// EMG activity detector.
// ----------------------------------------------------------------------------
package emg_pkg;

   localparam int SAMPLE_BITS_DEF = 12;

   localparam int Q_FRAC   = 20;
   localparam int STATE_W  = 32;
   localparam int OUT_W    = 20;
   localparam int OUT_LSB  = STATE_W - OUT_W;
   localparam int GAIN_W   = 21;
   localparam int THR_W    = 12;
   localparam int OPCODE_W = 2;

   localparam logic [STATE_W-1:0] MID_LEVEL = 32'h8000_0000;
   localparam logic [GAIN_W-1:0]  ONE_GAIN  = 21'h10_0000;

   localparam logic [GAIN_W-1:0] SMOOTH_GAIN_RST = 21'd104858;
   localparam logic [GAIN_W-1:0] DRIFT_GAIN_RST  = 21'd1049;
   localparam logic [THR_W-1:0]  THRESHOLD_RST   = 12'd100;

   localparam logic [OPCODE_W-1:0] OP_MEASURE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_TRACK   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR   = 2'd2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = GAIN_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTH_GAIN = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIFT_GAIN  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD   = 2'd2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // word passed from the front to the back half
   typedef struct packed {
      logic               meas;
      logic [STATE_W-1:0] level;
      logic [STATE_W-1:0] rest;
   } entry_type;

endpackage

// ===== rtl/emg_ema.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emg_ema
// One EMA update: old + round((g * ((x << 20) - old)) / 2^20), gain clamped
// to 1.0, result saturated to the state width.
// ----------------------------------------------------------------------------
module emg_ema #(
   parameter int SAMPLE_BITS = emg_pkg::SAMPLE_BITS_DEF
) (
   input  logic [emg_pkg::STATE_W-1:0] old_level,
   input  logic [SAMPLE_BITS-1:0]      sample,
   input  logic [emg_pkg::GAIN_W-1:0]  gain,
   output logic [emg_pkg::STATE_W-1:0] new_level
);

   localparam int XW = SAMPLE_BITS + emg_pkg::Q_FRAC;
   localparam int DW = ((XW > emg_pkg::STATE_W) ? XW : emg_pkg::STATE_W) + 1;
   localparam int GW = emg_pkg::GAIN_W + 1;
   localparam int PW = DW + GW;
   localparam logic signed [PW-1:0] HALF =
      {{(PW-emg_pkg::Q_FRAC){1'b0}}, 1'b1, {(emg_pkg::Q_FRAC-1){1'b0}}};

   logic [XW-1:0]                 x_q;
   logic signed [DW-1:0]          x_s;
   logic signed [DW-1:0]          old_s;
   logic signed [DW-1:0]          diff;
   logic [emg_pkg::GAIN_W-1:0]    g_clamped;
   logic signed [GW-1:0]          g_s;
   logic signed [PW-1:0]          prod;
   logic signed [PW-1:0]          step;
   logic signed [PW-1:0]          sum;

   assign x_q       = {sample, {emg_pkg::Q_FRAC{1'b0}}};
   assign x_s       = $signed({{(DW-XW){1'b0}}, x_q});
   assign old_s     = $signed({{(DW-emg_pkg::STATE_W){1'b0}}, old_level});
   assign diff      = x_s - old_s;
   assign g_clamped = (gain > emg_pkg::ONE_GAIN) ? emg_pkg::ONE_GAIN : gain;
   assign g_s       = $signed({1'b0, g_clamped});
   assign prod      = g_s * diff;
   assign step      = (prod + HALF) >>> emg_pkg::Q_FRAC;
   assign sum       = step + $signed({{(PW-emg_pkg::STATE_W){1'b0}}, old_level});

   // result lies between old and x, never negative
   assign new_level = (|sum[PW-1:emg_pkg::STATE_W]) ? {emg_pkg::STATE_W{1'b1}}
                                                    : sum[emg_pkg::STATE_W-1:0];

endmodule

// ===== rtl/emg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emg_front
// Accepts sample words, decodes the opcode, updates the smoothed level and
// the resting baseline, and pushes one word per sample into the queue.
// ----------------------------------------------------------------------------
module emg_front #(
   parameter int SAMPLE_BITS = emg_pkg::SAMPLE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [emg_pkg::OPCODE_W-1:0] opcode,
   input  logic [SAMPLE_BITS-1:0]       raw_sample,
   input  logic                         read_failed,
   input  logic [emg_pkg::GAIN_W-1:0]   smooth_gain,
   input  logic [emg_pkg::GAIN_W-1:0]   drift_gain,
   output emg_pkg::entry_type           push_word
);

   logic [emg_pkg::STATE_W-1:0] smoothed_ff, smoothed_in;
   logic [emg_pkg::STATE_W-1:0] rest_ff, rest_in;
   logic                        known_ff, known_in;
   logic [emg_pkg::STATE_W-1:0] smooth_next;
   logic [emg_pkg::STATE_W-1:0] drift_next;
   logic [emg_pkg::STATE_W-1:0] snap_level;
   logic                        is_meas;

   emg_ema #(.SAMPLE_BITS(SAMPLE_BITS)) u_smooth (
      .old_level (smoothed_ff),
      .sample    (raw_sample),
      .gain      (smooth_gain),
      .new_level (smooth_next)
   );

   emg_ema #(.SAMPLE_BITS(SAMPLE_BITS)) u_drift (
      .old_level (rest_ff),
      .sample    (raw_sample),
      .gain      (drift_gain),
      .new_level (drift_next)
   );

   assign snap_level = emg_pkg::STATE_W'({raw_sample, {emg_pkg::Q_FRAC{1'b0}}});
   assign is_meas    = ((opcode == emg_pkg::OP_MEASURE) || (opcode == emg_pkg::OP_TRACK))
                       && !read_failed;

   always_comb begin
      smoothed_in = smoothed_ff;
      rest_in     = rest_ff;
      known_in    = known_ff;
      if (accept) begin
         if (opcode == emg_pkg::OP_CLEAR) begin
            smoothed_in = emg_pkg::MID_LEVEL;
            rest_in     = emg_pkg::MID_LEVEL;
            known_in    = 1'b0;
         end else if (is_meas) begin
            smoothed_in = smooth_next;
            if (opcode == emg_pkg::OP_TRACK) begin
               known_in = 1'b1;
               rest_in  = known_ff ? drift_next : snap_level;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smoothed_ff <= emg_pkg::MID_LEVEL;
         rest_ff     <= emg_pkg::MID_LEVEL;
         known_ff    <= 1'b0;
      end else begin
         smoothed_ff <= smoothed_in;
         rest_ff     <= rest_in;
         known_ff    <= known_in;
      end
   end

   // activity uses the baseline as it stood before this sample
   assign push_word.meas  = is_meas;
   assign push_word.level = smooth_next;
   assign push_word.rest  = rest_ff;

endmodule

// ===== rtl/emg_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emg_queue
// Small register FIFO between the front and back halves.
// ----------------------------------------------------------------------------
module emg_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  emg_pkg::entry_type push_word,
   input  logic               pop,
   output logic               pop_valid,
   output emg_pkg::entry_type pop_word,
   output logic               full
);

   emg_pkg::entry_type               mem_ff [emg_pkg::QUEUE_DEPTH];
   logic [emg_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [emg_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [emg_pkg::QUEUE_CNT_W-1:0]  count_ff, count_in;

   localparam logic [emg_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
      emg_pkg::QUEUE_PTR_W'(emg_pkg::QUEUE_DEPTH - 1);
   localparam logic [emg_pkg::QUEUE_CNT_W-1:0] FULL_CNT =
      emg_pkg::QUEUE_CNT_W'(emg_pkg::QUEUE_DEPTH);

   assign pop_valid = (count_ff != '0);
   assign full      = (count_ff == FULL_CNT);
   assign pop_word  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ===== rtl/emg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emg_back
// Pops queue words, forms filtered level, activity and activation flag, and
// holds the result word in the output register.
// ----------------------------------------------------------------------------
module emg_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pop_valid,
   input  emg_pkg::entry_type          pop_word,
   output logic                        pop,
   input  logic [emg_pkg::THR_W-1:0]   threshold,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_sample_valid,
   output logic [emg_pkg::OUT_W-1:0]   rsp_filtered_level,
   output logic [emg_pkg::OUT_W-1:0]   rsp_activity_level,
   output logic                        rsp_high_activation
);

   logic                        valid_ff, valid_in;
   logic                        meas_ff;
   logic [emg_pkg::OUT_W-1:0]   filtered_ff;
   logic [emg_pkg::OUT_W-1:0]   activity_ff;
   logic                        high_ff;
   logic [emg_pkg::STATE_W-1:0] act;
   logic [emg_pkg::STATE_W-1:0] thr_level;
   logic                        high;

   assign pop       = pop_valid && (!valid_ff || !rsp_stall);
   assign act       = (pop_word.level > pop_word.rest) ? (pop_word.level - pop_word.rest)
                                                       : '0;
   assign thr_level = emg_pkg::STATE_W'({threshold, {emg_pkg::Q_FRAC{1'b0}}});
   assign high      = (act > thr_level);

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         meas_ff     <= pop_word.meas;
         filtered_ff <= pop_word.meas ? pop_word.level[emg_pkg::STATE_W-1:emg_pkg::OUT_LSB]
                                      : '0;
         activity_ff <= pop_word.meas ? act[emg_pkg::STATE_W-1:emg_pkg::OUT_LSB] : '0;
         high_ff     <= pop_word.meas && high;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_sample_valid    = meas_ff;
   assign rsp_filtered_level  = filtered_ff;
   assign rsp_activity_level  = activity_ff;
   assign rsp_high_activation = high_ff;

endmodule

// ===== rtl/emg_activity_detector_unit.sv =====
`timescale 1ns / 1ps
// Path: an accepted word is queued, then popped into the output register.
// Throughput: one word per cycle unless req_stall, set by the smoothed-level
// feedback, one multiply-add per cycle; a two-word queue separates front and back.
// Reset (synchronous): both averages return to 2048.0, the snap flag clears,
// gain and threshold registers return to defaults; no clearing pass.
// ----------------------------------------------------------------------------
// emg_activity_detector_unit
// EMA filter with baseline tracking and threshold detection for EMG samples.
// ----------------------------------------------------------------------------
module emg_activity_detector_unit #(
   parameter int SAMPLE_BITS = emg_pkg::SAMPLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [emg_pkg::OPCODE_W-1:0]    req_opcode,
   input  logic [SAMPLE_BITS-1:0]          req_raw_sample,
   input  logic                            req_read_failed,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_sample_valid,
   output logic [emg_pkg::OUT_W-1:0]       rsp_filtered_level,
   output logic [emg_pkg::OUT_W-1:0]       rsp_activity_level,
   output logic                            rsp_high_activation,
   input  logic                            csr_write_en,
   input  logic [emg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [emg_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic [emg_pkg::GAIN_W-1:0] smooth_gain_ff;
   logic [emg_pkg::GAIN_W-1:0] drift_gain_ff;
   logic [emg_pkg::THR_W-1:0]  threshold_ff;
   logic                       accept;
   logic                       q_full;
   logic                       q_pop;
   logic                       q_valid;
   emg_pkg::entry_type         push_word;
   emg_pkg::entry_type         pop_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_gain_ff <= emg_pkg::SMOOTH_GAIN_RST;
         drift_gain_ff  <= emg_pkg::DRIFT_GAIN_RST;
         threshold_ff   <= emg_pkg::THRESHOLD_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            emg_pkg::CSR_SMOOTH_GAIN: smooth_gain_ff <= csr_wdata;
            emg_pkg::CSR_DRIFT_GAIN:  drift_gain_ff  <= csr_wdata;
            emg_pkg::CSR_THRESHOLD:   threshold_ff   <= csr_wdata[emg_pkg::THR_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   emg_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .opcode      (req_opcode),
      .raw_sample  (req_raw_sample),
      .read_failed (req_read_failed),
      .smooth_gain (smooth_gain_ff),
      .drift_gain  (drift_gain_ff),
      .push_word   (push_word)
   );

   emg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_word (push_word),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_word  (pop_word),
      .full      (q_full)
   );

   emg_back u_back (
      .clock               (clock),
      .reset               (reset),
      .pop_valid           (q_valid),
      .pop_word            (pop_word),
      .pop                 (q_pop),
      .threshold           (threshold_ff),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_sample_valid    (rsp_sample_valid),
      .rsp_filtered_level  (rsp_filtered_level),
      .rsp_activity_level  (rsp_activity_level),
      .rsp_high_activation (rsp_high_activation)
   );

endmodule

// ===== dv/emg_activity_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emg_activity_checker
// Passive checker for the EMG activity detector. It snoops register writes and
// every accepted sample word, predicts the filter, baseline and activity
// result of each one, and compares the results in order as they are accepted.
// ----------------------------------------------------------------------------
module emg_activity_checker
   import emg_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [OPCODE_W-1:0]    req_opcode,
   input  logic [SAMPLE_BITS-1:0] req_raw_sample,
   input  logic                   req_read_failed,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic                   rsp_sample_valid,
   input  logic [OUT_W-1:0]       rsp_filtered_level,
   input  logic [OUT_W-1:0]       rsp_activity_level,
   input  logic                   rsp_high_activation,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     error_count,
   output int                     pending_words
);

   typedef struct packed {
      logic             sample_valid;
      logic [OUT_W-1:0] filtered;
      logic [OUT_W-1:0] activity;
      logic             high;
   } activity_word_type;

   activity_word_type  due_results[$];
   activity_word_type  seen_word;
   activity_word_type  due_word;
   int                 errors = 0;

   logic [STATE_W-1:0] level_avg;
   logic [STATE_W-1:0] baseline;
   logic               baseline_snapped;
   logic [GAIN_W-1:0]  smooth_gain_q;
   logic [GAIN_W-1:0]  drift_gain_q;
   logic [THR_W-1:0]   threshold_q;

   // one EMA step, round half up, gain saturated at 1.0
   function automatic logic [STATE_W-1:0] ema_update(input logic [STATE_W-1:0] prev,
                                                     input logic [SAMPLE_BITS-1:0] x,
                                                     input logic [GAIN_W-1:0] gain);
      logic [63:0] g;
      logic [63:0] acc;
      g   = (gain > ONE_GAIN) ? 64'(ONE_GAIN) : 64'(gain);
      acc = g * (64'(x) << Q_FRAC) + (64'(ONE_GAIN) - g) * 64'(prev)
            + (64'(ONE_GAIN) >> 1);
      acc = acc >> Q_FRAC;
      return (acc > 64'hFFFF_FFFF) ? '1 : acc[STATE_W-1:0];
   endfunction

   function automatic activity_word_type filter_sample(input logic [OPCODE_W-1:0] op,
                                                       input logic [SAMPLE_BITS-1:0] raw,
                                                       input logic failed);
      activity_word_type r;
      logic [STATE_W-1:0] diff;
      r = '0;
      if (op == OP_CLEAR) begin
         level_avg        = MID_LEVEL;
         baseline         = MID_LEVEL;
         baseline_snapped = 1'b0;
      end else if ((op == OP_MEASURE || op == OP_TRACK) && !failed) begin
         level_avg      = ema_update(level_avg, raw, smooth_gain_q);
         diff           = (level_avg > baseline) ? level_avg - baseline : '0;
         r.sample_valid = 1'b1;
         r.filtered     = level_avg[STATE_W-1:OUT_LSB];
         r.activity     = diff[STATE_W-1:OUT_LSB];
         r.high         = 64'(diff) > (64'(threshold_q) << Q_FRAC);
         if (op == OP_TRACK) begin
            if (!baseline_snapped) begin
               baseline         = STATE_W'(raw) << Q_FRAC;
               baseline_snapped = 1'b1;
            end else begin
               baseline = ema_update(baseline, raw, drift_gain_q);
            end
         end
      end
      return r;
   endfunction

   function automatic void note_error(input string what);
      errors++;
      if (errors <= 10)
         $display("%0t: %s: expected v=%0d lvl=%h act=%h hi=%0d, got v=%0d lvl=%h act=%h hi=%0d",
                  $time, what, due_word.sample_valid, due_word.filtered, due_word.activity,
                  due_word.high, seen_word.sample_valid, seen_word.filtered,
                  seen_word.activity, seen_word.high);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         level_avg        = MID_LEVEL;
         baseline         = MID_LEVEL;
         baseline_snapped = 1'b0;
         smooth_gain_q    = SMOOTH_GAIN_RST;
         drift_gain_q     = DRIFT_GAIN_RST;
         threshold_q      = THRESHOLD_RST;
         due_results.delete();
      end else begin
         // compare before pushing: a word cannot come back at its own edge
         if (rsp_valid && !rsp_stall) begin
            seen_word = '{rsp_sample_valid, rsp_filtered_level, rsp_activity_level,
                          rsp_high_activation};
            if (due_results.size() == 0) begin
               due_word = '0;
               note_error("unexpected word");
            end else begin
               due_word = due_results.pop_front();
               if (seen_word !== due_word)
                  note_error("mismatch");
            end
         end
         if (req_valid && !req_stall)
            due_results.push_back(filter_sample(req_opcode, req_raw_sample, req_read_failed));
         // a register write takes effect after its edge
         if (csr_write_en) begin
            case (csr_index)
               CSR_SMOOTH_GAIN: smooth_gain_q = csr_wdata[GAIN_W-1:0];
               CSR_DRIFT_GAIN:  drift_gain_q  = csr_wdata[GAIN_W-1:0];
               CSR_THRESHOLD:   threshold_q   = csr_wdata[THR_W-1:0];
               default: ;
            endcase
         end
      end
      pending_words <= due_results.size();
      error_count   <= errors;
   end

endmodule

// ===== dv/tb_emg_activity_detector_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_emg_activity_detector_unit
// Drives directed and random sample words into the EMG activity detector
// under several gain and threshold settings and changing backpressure; the
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_emg_activity_detector_unit;
   import emg_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam int RAW_W       = SAMPLE_BITS_DEF;
   localparam int RAW_MAX     = (1 << RAW_W) - 1;
   localparam int HOLD_CYCLES = 60;
   localparam int ITEMS_PHASE = 230;
   localparam int CYCLE_LIMIT = 300000;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [OPCODE_W-1:0]    req_opcode;
   logic [RAW_W-1:0]       req_raw_sample;
   logic                   req_read_failed;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_sample_valid;
   logic [OUT_W-1:0]       rsp_filtered_level;
   logic [OUT_W-1:0]       rsp_activity_level;
   logic                   rsp_high_activation;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int   error_count;
   int   pending_words;
   int   send_idle_pct = 32;
   int   recv_idle_pct = 60;
   logic hold_req;
   logic hold_done;
   int   burst_level = 2048;
   int   burst_left = 0;
   int   cycles = 0;

   emg_activity_detector_unit dut (.*);

   emg_activity_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver: random stall, plus one long hold-off on request
   initial begin
      hold_done = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [RAW_W-1:0] raw,
                            input logic failed);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_raw_sample  <= raw;
      req_read_failed <= failed;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_random();
      int pick;
      int raw;
      logic [OPCODE_W-1:0] op;
      if (burst_left == 0) begin
         burst_level = $urandom_range(0, RAW_MAX);
         burst_left  = $urandom_range(4, 40);
      end
      burst_left--;
      pick = $urandom_range(99);
      if (pick < 3)
         op = OP_CLEAR;
      else if (pick < 6)
         op = OP_UNUSED;
      else if (pick < 50)
         op = OP_TRACK;
      else
         op = OP_MEASURE;
      if ($urandom_range(99) < 20) begin
         raw = $urandom_range(0, RAW_MAX);
      end else begin
         raw = burst_level + $urandom_range(0, 64) - 32;
         raw = (raw < 0) ? 0 : (raw > RAW_MAX) ? RAW_MAX : raw;
      end
      send_word(op, RAW_W'(raw), $urandom_range(99) < 6);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input logic [GAIN_W-1:0] smooth, input logic [GAIN_W-1:0] drift,
                            input logic [THR_W-1:0] thr);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_SMOOTH_GAIN;
      csr_wdata    <= smooth;
      @(posedge clock);
      csr_index    <= CSR_DRIFT_GAIN;
      csr_wdata    <= drift;
      @(posedge clock);
      csr_index    <= CSR_THRESHOLD;
      csr_wdata    <= CSR_DATA_W'(thr);
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      reset           <= 1'b1;
      hold_req        <= 1'b0;
      req_valid       <= 1'b0;
      req_opcode      <= OP_MEASURE;
      req_raw_sample  <= '0;
      req_read_failed <= 1'b0;
      csr_write_en    <= 1'b0;
      csr_index       <= CSR_SMOOTH_GAIN;
      csr_wdata       <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words under reset defaults
      send_word(OP_MEASURE, 12'd0, 1'b0);
      send_word(OP_MEASURE, 12'hFFF, 1'b0);
      send_word(OP_TRACK, 12'hFFF, 1'b0);
      send_word(OP_TRACK, 12'd0, 1'b0);
      send_word(OP_MEASURE, 12'hAAA, 1'b1);
      send_word(OP_TRACK, 12'h555, 1'b1);
      send_word(OP_UNUSED, 12'h123, 1'b0);
      send_word(OP_UNUSED, 12'hFFF, 1'b1);
      send_word(OP_CLEAR, 12'hFFF, 1'b1);
      send_word(OP_MEASURE, 12'hAAA, 1'b0);
      send_word(OP_MEASURE, 12'h555, 1'b0);
      send_word(OP_CLEAR, 12'd0, 1'b0);
      send_word(OP_TRACK, 12'd0, 1'b0);
      for (int i = 0; i < 8; i++)
         send_word(OP_MEASURE, 12'hFFF, 1'b0);
      send_word(OP_TRACK, 12'h800, 1'b0);
      send_word(OP_MEASURE, 12'd0, 1'b0);
      send_word(OP_CLEAR, 12'h7FF, 1'b0);

      for (int phase = 0; phase < 6; phase++) begin
         drain();
         if (phase < 2) begin
            send_idle_pct = 32;
            recv_idle_pct = 60;
         end else if (phase < 4) begin
            send_idle_pct = 60;
            recv_idle_pct = 32;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (phase)
            0: configure(SMOOTH_GAIN_RST, DRIFT_GAIN_RST, THRESHOLD_RST);
            1: configure('0, '0, '0);
            2: configure(ONE_GAIN, ONE_GAIN, '1);
            3: configure('1, '1, '0);
            4: configure(GAIN_W'($urandom_range(0, ONE_GAIN)),
                         GAIN_W'($urandom_range(0, 1 << 16)),
                         THR_W'($urandom_range(0, 300)));
            default: configure(GAIN_W'($urandom_range(0, (1 << GAIN_W) - 1)),
                               GAIN_W'($urandom_range(0, (1 << GAIN_W) - 1)),
                               THR_W'($urandom_range(0, (1 << THR_W) - 1)));
         endcase
         for (int i = 0; i < ITEMS_PHASE; i++) begin
            if (phase == 4 && i == 100)
               hold_req <= 1'b1;
            send_random();
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (error_count == 0 && pending_words == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/emg_pkg.sv
rtl/emg_ema.sv
rtl/emg_front.sv
rtl/emg_queue.sv
rtl/emg_back.sv
rtl/emg_activity_detector_unit.sv
dv/emg_activity_checker.sv
dv/tb_emg_activity_detector_unit.sv
